FILE: design/euclidean_distance_4d_macros.svh
// Assertion helpers shared by the distance pipeline.
// Every module that uses them has a clock clk_i and an active-low reset rst_ni.
`ifndef EUCLIDEAN_DISTANCE_4D_MACROS_SVH
`define EUCLIDEAN_DISTANCE_4D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ED4D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ED4D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ed4d_pkg.sv
package ed4d_pkg;

  // Number of axes and the coordinate format.
  localparam int DIMS = 4;
  localparam int COORD_W = 16;
  localparam logic signed [COORD_W-1:0] COORD_LIMIT = 16'sd16384;

  // Magnitude of a difference, a square, the sum of squares and the root.
  localparam int MAG_W = 16;
  localparam int SQ_W = 31;
  localparam int SUM_W = 33;
  localparam int RAD_W = 34;
  localparam int ROOT_W = 17;
  localparam int REM_W = 19;

  typedef logic [DIMS-1:0][COORD_W-1:0] coord_vec_t;
  typedef logic [DIMS-1:0][MAG_W-1:0] mag_vec_t;
  typedef logic [DIMS-1:0][SQ_W-1:0] sq_vec_t;

  // Working state of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // Clamp a coordinate to the range -1.0 .. +1.0.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] v;
    v = $signed(raw);
    if (v > COORD_LIMIT) begin
      v = COORD_LIMIT;
    end else if (v < -COORD_LIMIT) begin
      v = -COORD_LIMIT;
    end
    return v;
  endfunction

  // Absolute difference of two clamped coordinates; at most 32768.
  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic signed [COORD_W-1:0] sa;
    logic signed [COORD_W-1:0] sb;
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    sa = sat_coord(a);
    sb = sat_coord(b);
    d = {sa[COORD_W-1], sa} - {sb[COORD_W-1], sb};
    m = d[COORD_W] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

  // One result digit of the restoring square root: bring down two radicand
  // bits, try to subtract 4*root+1, and shift the outcome into the root.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sqrt_st_t n;
    acc = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      n.rem = REM_W'(acc - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem = acc[REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

FILE: design/euclidean_distance_4d.sv
// Four-dimensional Euclidean distance, fully pipelined.
// Input channel: the eight coordinates (signed Q1.14, clamped to -1.0..+1.0)
// are taken as one beat at a rising edge with start_i high and busy_o low.
// busy_o is always low, so a new beat may enter in every cycle.
// Output channel: distance_o (unsigned Q.14, 0..65536) is shown for exactly
// one cycle with valid_o high; the receiver has no way to hold it.
// Throughput is one beat per cycle, set by the fact that every unit
// (difference, multipliers, adder, root stages) has its own stage.
// Stages: clamp and difference, four squares, sum, then the restoring
// square root, up to DigitsPerStage compare-subtract steps per stage.
// Reset clears every stage valid bit, dropping beats in flight; no beat is
// produced until a new one is accepted. The block keeps no state between
// beats, so results come out in the order the beats went in.
`include "euclidean_distance_4d_macros.svh"

module euclidean_distance_4d #(
  parameter int DigitsPerStage = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  first_x_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  first_y_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  first_z_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  first_t_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  second_x_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  second_y_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  second_z_i,
  input  logic signed [ed4d_pkg::COORD_W-1:0]  second_t_i,
  output logic                                 valid_o,
  output logic [ed4d_pkg::ROOT_W-1:0]          distance_o
);

  localparam int SqrtStages =
    (ed4d_pkg::ROOT_W + DigitsPerStage - 1) / DigitsPerStage;
  localparam int Latency = 3 + SqrtStages;

  logic                         accept;
  ed4d_pkg::coord_vec_t         first_vec;
  ed4d_pkg::coord_vec_t         second_vec;
  logic                         diff_valid;
  ed4d_pkg::mag_vec_t           diff_mag;
  logic                         sum_valid;
  logic [ed4d_pkg::SUM_W-1:0]   sum;

  // The pipeline never stalls, so a beat is taken whenever start_i is high.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Gather the coordinates by axis: x, y, z, t.
  assign first_vec  = {first_t_i, first_z_i, first_y_i, first_x_i};
  assign second_vec = {second_t_i, second_z_i, second_y_i, second_x_i};

  ed4d_diff u_diff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .first_i  (first_vec),
    .second_i (second_vec),
    .valid_o  (diff_valid),
    .mag_o    (diff_mag)
  );

  ed4d_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .mag_i   (diff_mag),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  ed4d_sqrt #(
    .DigitsPerStage (DigitsPerStage)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .valid_o (valid_o),
    .root_o  (distance_o)
  );

  `ED4D_ASSERT_NOW(a_beat_out, accept, ##Latency valid_o, "accepted beat produced no result")
  `ED4D_ASSERT_NOW(a_no_phantom, valid_o, $past(accept, Latency),
    "result strobe without an accepted beat")
  `ED4D_ASSERT_NOW(a_range, valid_o, distance_o <= 17'd65536, "distance out of range")

endmodule

FILE: design/ed4d_diff.sv
module ed4d_diff (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  ed4d_pkg::coord_vec_t  first_i,
  input  ed4d_pkg::coord_vec_t  second_i,
  output logic                  valid_o,
  output ed4d_pkg::mag_vec_t    mag_o
);

  logic               valid_q;
  ed4d_pkg::mag_vec_t mag_d;
  ed4d_pkg::mag_vec_t mag_q;

  // Clamp each coordinate and form the magnitude of each axis difference.
  always_comb begin
    for (int k = 0; k < ed4d_pkg::DIMS; k++) begin
      mag_d[k] = ed4d_pkg::abs_diff(first_i[k], second_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign valid_o = valid_q;
  assign mag_o = mag_q;

endmodule

FILE: design/ed4d_sqsum.sv
module ed4d_sqsum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  ed4d_pkg::mag_vec_t               mag_i,
  output logic                             valid_o,
  output logic [ed4d_pkg::SUM_W-1:0]       sum_o
);

  logic                         sq_valid_q;
  logic                         sum_valid_q;
  ed4d_pkg::sq_vec_t            sq_d;
  ed4d_pkg::sq_vec_t            sq_q;
  logic [ed4d_pkg::SUM_W-1:0]   sum_d;
  logic [ed4d_pkg::SUM_W-1:0]   sum_q;

  // One multiplier per axis; a magnitude of at most 2^15 squares into 31 bits.
  always_comb begin
    for (int k = 0; k < ed4d_pkg::DIMS; k++) begin
      sq_d[k] = ed4d_pkg::SQ_W'(mag_i[k]) * ed4d_pkg::SQ_W'(mag_i[k]);
    end
  end

  // Exact sum of the four registered squares.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < ed4d_pkg::DIMS; k++) begin
      sum_d = sum_d + ed4d_pkg::SUM_W'(sq_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= valid_i;
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    sum_q <= sum_d;
  end

  assign valid_o = sum_valid_q;
  assign sum_o = sum_q;

endmodule

FILE: design/ed4d_sqrt.sv
`include "euclidean_distance_4d_macros.svh"

module ed4d_sqrt #(
  parameter int DigitsPerStage = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ed4d_pkg::SUM_W-1:0]    sum_i,
  output logic                          valid_o,
  output logic [ed4d_pkg::ROOT_W-1:0]   root_o
);

  localparam int Stages = (ed4d_pkg::ROOT_W + DigitsPerStage - 1) / DigitsPerStage;

  ed4d_pkg::sqrt_st_t  st_in;
  ed4d_pkg::sqrt_st_t  st_d [Stages];
  ed4d_pkg::sqrt_st_t  st_q [Stages];
  logic [Stages-1:0]   vld_q;
  logic [ed4d_pkg::REM_W-1:0] rem_bound;

  // Start with an empty root and remainder; the radicand is padded to even width.
  assign st_in.rad  = ed4d_pkg::RAD_W'(sum_i);
  assign st_in.rem  = '0;
  assign st_in.root = '0;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    // Each stage resolves up to DigitsPerStage root bits, most significant first.
    always_comb begin
      st_d[s] = (s == 0) ? st_in : st_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < DigitsPerStage; j++) begin
        if (s * DigitsPerStage + j < ed4d_pkg::ROOT_W) begin
          st_d[s] = ed4d_pkg::sqrt_step(st_d[s]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d[s];
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign root_o = st_q[Stages-1].root;

  // A finished root leaves a remainder of at most twice the root.
  assign rem_bound = {1'b0, st_q[Stages-1].root, 1'b0};

  `ED4D_ASSERT_NOW(a_rem_bound, vld_q[Stages-1], st_q[Stages-1].rem <= rem_bound,
    "square root remainder exceeds twice the root")
  `ED4D_ASSERT_NEXT(a_vld_enter, valid_i, vld_q[0], "beat lost entering the root pipeline")

endmodule
